// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the CSMA/CD station RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/csmacd_pkg.sv =====
// Shared types and constants of the CSMA/CD station MAC.
// No dependencies; used by every module of the block.
package csmacd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_LENGTH = 2'd0;
    localparam logic [1:0] CFG_SLOT_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_JAM_LENGTH   = 2'd2;

    // Configuration reset values
    localparam logic [15:0] FRAME_LENGTH_RESET = 16'd8000;
    localparam logic [9:0]  SLOT_LENGTH_RESET  = 10'd512;
    localparam logic [7:0]  JAM_LENGTH_RESET   = 8'd32;

    // Backoff limits
    localparam logic [4:0] COLLISION_CAP = 5'd16;
    localparam logic [4:0] EXPONENT_CAP  = 5'd10;

    typedef struct packed {
        logic [15:0] frame_length_bits;
        logic [9:0]  slot_length_bits;
        logic [7:0]  jam_length_bits;
    } cfg_t;

    typedef struct packed {
        logic [1:0] new_frames;
        logic       channel_busy;
        logic       outside_collision;
        logic       persist_granted;
        logic [9:0] backoff_draw;
    } step_item_t;

    typedef struct packed {
        logic        sending;
        logic        jamming;
        logic        backing_off;
        logic        frame_delivered;
        logic [31:0] delivery_delay;
        logic [4:0]  queued_frames;
        logic [1:0]  dropped_frames;
        logic [4:0]  collision_count;
    } step_result_t;

    // Arrival queue control from the station core
    typedef struct packed {
        logic       push;
        logic [1:0] push_cnt;
        logic       pop;
    } fifo_ctl_t;

endpackage

// ===== hw/rtl/csmacd_arrival_fifo.sv =====
// Arrival-time queue: one memory entry per bit time with arrivals (time and count),
// plus a two-slot prefetch buffer that keeps the head time in registers. Uses csmacd_pkg.
`include "assert_macros.svh"

module csmacd_arrival_fifo #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csmacd_pkg::fifo_ctl_t ctl,
    input  logic [31:0]           push_time,
    output logic [31:0]           head_time
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);

    logic [33:0]   mem [QUEUE_DEPTH];
    logic [33:0]   rdata_reg;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] mem_count_reg, mem_count_next;
    logic          rd_pend_reg;
    logic [1:0]    buf_cnt_reg, buf_cnt_next;
    logic [31:0]   slot_time_reg [2];
    logic [31:0]   slot_time_next [2];
    logic [1:0]    slot_left_reg [2];
    logic [1:0]    slot_left_next [2];

    logic       pop_group;
    logic       issue;
    logic       direct;
    logic       mem_wr;
    logic [1:0] c1, c2;

    // Consume the head, then append read data and a bypassed push in order
    always_comb
    begin
        slot_time_next = slot_time_reg;
        slot_left_next = slot_left_reg;
        pop_group      = ctl.pop && (slot_left_reg[0] == 2'd1);
        c1             = buf_cnt_reg;
        if (pop_group)
        begin
            slot_time_next[0] = slot_time_reg[1];
            slot_left_next[0] = slot_left_reg[1];
            c1                = buf_cnt_reg - 2'd1;
        end
        else if (ctl.pop)
        begin
            slot_left_next[0] = slot_left_reg[0] - 2'd1;
        end
        c2 = c1;
        if (rd_pend_reg)
        begin
            slot_time_next[c1[0]] = rdata_reg[31:0];
            slot_left_next[c1[0]] = rdata_reg[33:32];
            c2                    = c1 + 2'd1;
        end
        issue  = (mem_count_reg != '0) && (c2 != 2'd2);
        direct = ctl.push && (mem_count_reg == '0) && (c2 != 2'd2);
        mem_wr = ctl.push && !direct;
        buf_cnt_next = c2;
        if (direct)
        begin
            slot_time_next[c2[0]] = push_time;
            slot_left_next[c2[0]] = ctl.push_cnt;
            buf_cnt_next          = c2 + 2'd1;
        end
        wr_ptr_next = wr_ptr_reg;
        if (mem_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + AW'(1);
        end
        rd_ptr_next = rd_ptr_reg;
        if (issue)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + AW'(1);
        end
        mem_count_next = mem_count_reg + CW'(mem_wr) - CW'(issue);
    end

    // Hold pointers and buffer occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            mem_count_reg <= '0;
            rd_pend_reg   <= 1'b0;
            buf_cnt_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            mem_count_reg <= mem_count_next;
            rd_pend_reg   <= issue;
            buf_cnt_reg   <= buf_cnt_next;
        end
    end

    // Prefetch slots carry payload only
    always_ff @(posedge clk)
    begin
        slot_time_reg <= slot_time_next;
        slot_left_reg <= slot_left_next;
    end

    // Group memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wr_ptr_reg] <= {ctl.push_cnt, push_time};
        end
        if (issue)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign head_time = slot_time_reg[0];

    `ASSERT_IMPL(a_pop_has_head, clk, rst_n, ctl.pop, buf_cnt_reg != 2'd0)
    `ASSERT_IMPL(a_pend_has_room, clk, rst_n, rd_pend_reg, buf_cnt_reg != 2'd2)
    `ASSERT_IMPL(a_head_before_backlog, clk, rst_n, (mem_count_reg != '0) || rd_pend_reg, buf_cnt_reg != 2'd0)
    `ASSERT_CLK(a_buf_bounded, clk, rst_n, buf_cnt_reg != 2'd3)

endmodule

// ===== hw/rtl/csmacd_step_core.sv =====
// Station state and the single-pass step logic: arrivals, collision, countdowns,
// binary exponential backoff and frame start. Uses csmacd_pkg.
`include "assert_macros.svh"

module csmacd_step_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  csmacd_pkg::step_item_t   item,
    input  csmacd_pkg::cfg_t         cfg,
    input  logic [31:0]              head_time,
    output csmacd_pkg::fifo_ctl_t    fifo_ctl,
    output logic [31:0]              push_time,
    output csmacd_pkg::step_result_t result
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SEND,
        MODE_JAM,
        MODE_BACKOFF
    } mode_t;

    mode_t       mode_reg, mode_a, mode_b, mode_c;
    logic [19:0] rem_reg, rem_a, rem_dec, rem_b, rem_c;
    logic [4:0]  coll_reg, coll_a, coll_b;
    logic [FW-1:0] fill_reg, fill_arr, fill_b;
    logic [31:0] clock_reg;
    logic [9:0]  phase_reg, phase_next;
    logic [10:0] phase_inc;

    logic [FW-1:0] room;
    logic [1:0]    acc;
    logic [1:0]    dropped;
    logic [3:0]    exp_m;
    logic [10:0]   mask;
    logic [9:0]    slots;
    logic [19:0]   backoff_bits;
    logic          deliver;
    logic [31:0]   fill_wide;

    // Compute one bit time of station behavior
    always_comb
    begin
        // queue the arrivals, drop what does not fit
        room    = FW'(QUEUE_DEPTH) - fill_reg;
        acc     = (room >= FW'(item.new_frames)) ? item.new_frames : room[1:0];
        dropped = item.new_frames - acc;
        fill_arr = fill_reg + FW'(acc);

        // collision on own transmission starts the jam
        mode_a = mode_reg;
        rem_a  = rem_reg;
        coll_a = coll_reg;
        if ((mode_reg == MODE_SEND) && (item.channel_busy || item.outside_collision))
        begin
            mode_a = MODE_JAM;
            rem_a  = 20'(cfg.jam_length_bits);
            if (coll_reg < csmacd_pkg::COLLISION_CAP)
            begin
                coll_a = coll_reg + 5'd1;
            end
        end

        // backoff window from the low bits of the draw
        exp_m = (coll_a < csmacd_pkg::EXPONENT_CAP) ? coll_a[3:0]
                                                    : csmacd_pkg::EXPONENT_CAP[3:0];
        mask  = (11'd1 << exp_m) - 11'd1;
        slots = item.backoff_draw & mask[9:0];
        backoff_bits = 20'(slots) * 20'(cfg.slot_length_bits);

        // run down jam, backoff or transmission
        rem_dec = (rem_a != 20'd0) ? rem_a - 20'd1 : 20'd0;
        mode_b  = mode_a;
        rem_b   = rem_a;
        coll_b  = coll_a;
        fill_b  = fill_arr;
        deliver = 1'b0;
        unique case (mode_a)
            MODE_JAM:
            begin
                rem_b = rem_dec;
                if (rem_dec == 20'd0)
                begin
                    mode_b = MODE_BACKOFF;
                    rem_b  = backoff_bits;
                end
            end
            MODE_BACKOFF:
            begin
                rem_b = rem_dec;
                if (rem_dec == 20'd0)
                begin
                    mode_b = MODE_IDLE;
                end
            end
            MODE_SEND:
            begin
                rem_b = rem_dec;
                if (rem_dec == 20'd0)
                begin
                    mode_b = MODE_IDLE;
                    if (fill_arr != '0)
                    begin
                        deliver = 1'b1;
                        fill_b  = fill_arr - FW'(1);
                    end
                    coll_b = 5'd0;
                end
            end
            MODE_IDLE:
            begin
                rem_b = rem_a;
            end
            default:
            begin
                rem_b = rem_a;
            end
        endcase

        // start a frame on a slot boundary with a free channel
        mode_c = mode_b;
        rem_c  = rem_b;
        if ((mode_b == MODE_IDLE) && !item.channel_busy && (phase_reg == 10'd0) &&
            (fill_b != '0) && item.persist_granted)
        begin
            mode_c = MODE_SEND;
            rem_c  = 20'(cfg.frame_length_bits);
        end

        // advance the slot phase
        phase_inc  = 11'(phase_reg) + 11'd1;
        phase_next = (phase_inc >= 11'(cfg.slot_length_bits)) ? 10'd0 : phase_inc[9:0];

        fill_wide = 32'(fill_b);
    end

    // Drive the arrival queue
    always_comb
    begin
        fifo_ctl.push     = step && (acc != 2'd0);
        fifo_ctl.push_cnt = acc;
        fifo_ctl.pop      = step && deliver;
    end
    assign push_time = clock_reg;

    // Assemble the result of this step
    always_comb
    begin
        result.sending         = (mode_c == MODE_SEND);
        result.jamming         = (mode_c == MODE_JAM);
        result.backing_off     = (mode_c == MODE_BACKOFF);
        result.frame_delivered = deliver;
        result.delivery_delay  = deliver ? (clock_reg - head_time) : 32'd0;
        result.queued_frames   = fill_wide[4:0];
        result.dropped_frames  = dropped;
        result.collision_count = coll_b;
    end

    // Hold station state; advance once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            rem_reg   <= 20'd0;
            coll_reg  <= 5'd0;
            fill_reg  <= '0;
            clock_reg <= 32'd0;
            phase_reg <= 10'd0;
        end
        else if (step)
        begin
            mode_reg  <= mode_c;
            rem_reg   <= rem_c;
            coll_reg  <= coll_b;
            fill_reg  <= fill_b;
            clock_reg <= clock_reg + 32'd1;
            phase_reg <= phase_next;
        end
    end

    `ASSERT_IMPL(a_jam_after_collision, clk, rst_n, mode_reg == MODE_JAM, coll_reg != 5'd0)
    `ASSERT_IMPL(a_send_has_frame, clk, rst_n, mode_reg == MODE_SEND, fill_reg != '0)
    `ASSERT_IMPL(a_delivery_ends_send, clk, rst_n, step && deliver, mode_reg == MODE_SEND)

endmodule

// ===== hw/rtl/csma_cd_station_mac_unit.sv =====
// CSMA/CD station MAC, one bit time per input transaction.
// The input transaction is captured in an input register and the step result in a result
// register, so each result passes through both registers before it is offered.
// Throughput: one transaction per cycle while no result waits to be taken; the step logic
// and the arrival queue's memory port each handle one bit time per cycle.
// Reset (rst_n, asynchronous, active low): station idle, queue empty, clocks zero,
// configuration at frame 8000, slot 512, jam 32 bit times; no clearing pass.
module csma_cd_station_mac_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // new_frames[1:0], channel_busy[2], outside_collision[3], persist_granted[4],
    // backoff_draw[14:5], zero[15]
    input  logic [15:0] s_axis_tdata,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sending[0], jamming[1], backing_off[2], frame_delivered[3],
    // delivery_delay[35:4], queued_frames[40:36], dropped_frames[42:41],
    // collision_count[47:43]
    output logic [47:0] m_axis_tdata
);

    csmacd_pkg::cfg_t         cfg_reg;
    csmacd_pkg::step_item_t   in_item_reg;
    logic                     in_valid_reg;
    logic                     out_valid_reg;
    csmacd_pkg::step_result_t out_data_reg;
    csmacd_pkg::step_result_t result;
    csmacd_pkg::fifo_ctl_t    fifo_ctl;
    logic [31:0]              push_time;
    logic [31:0]              head_time;
    logic                     advance;
    logic                     step;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_length_bits <= csmacd_pkg::FRAME_LENGTH_RESET;
            cfg_reg.slot_length_bits  <= csmacd_pkg::SLOT_LENGTH_RESET;
            cfg_reg.jam_length_bits   <= csmacd_pkg::JAM_LENGTH_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                csmacd_pkg::CFG_FRAME_LENGTH: cfg_reg.frame_length_bits <= cfg_wdata;
                csmacd_pkg::CFG_SLOT_LENGTH:  cfg_reg.slot_length_bits  <= cfg_wdata[9:0];
                csmacd_pkg::CFG_JAM_LENGTH:   cfg_reg.jam_length_bits   <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Stall the step while a result waits to be taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = advance || !in_valid_reg;
    assign m_axis_tvalid = out_valid_reg;

    // Hold stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Capture the input transaction and the result
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.new_frames        <= s_axis_tdata[1:0];
            in_item_reg.channel_busy      <= s_axis_tdata[2];
            in_item_reg.outside_collision <= s_axis_tdata[3];
            in_item_reg.persist_granted   <= s_axis_tdata[4];
            in_item_reg.backoff_draw      <= s_axis_tdata[14:5];
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    csmacd_step_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .head_time (head_time),
        .fifo_ctl  (fifo_ctl),
        .push_time (push_time),
        .result    (result)
    );

    csmacd_arrival_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fifo_ctl),
        .push_time (push_time),
        .head_time (head_time)
    );

    // Pack the result fields
    assign m_axis_tdata = {out_data_reg.collision_count,
                           out_data_reg.dropped_frames,
                           out_data_reg.queued_frames,
                           out_data_reg.delivery_delay,
                           out_data_reg.frame_delivered,
                           out_data_reg.backing_off,
                           out_data_reg.jamming,
                           out_data_reg.sending};

endmodule

// ===== sim/csma_cd_station_mac_unit_test.sv =====
// Self-checking testbench of the CSMA/CD station MAC, one bit time per transaction.
// Drives directed and random bit times under several configurations and checks every result.
// Depends on csmacd_pkg and csma_cd_station_mac_unit.
module csma_cd_station_mac_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATION_QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RING_DEPTH = 64;
    // Index outside the register map: the write must be ignored
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEND,
        ST_JAM,
        ST_BACKOFF
    } station_mode_t;

    // Station predictor and store of expected results
    class station_ledger;
        int unsigned frame_len;
        int unsigned slot_len;
        int unsigned jam_len;
        logic [31:0] stamps [STATION_QUEUE_DEPTH];
        int unsigned head;
        int unsigned fill;
        logic [31:0] bit_time;
        int unsigned phase;
        station_mode_t mode;
        int unsigned remaining;
        int unsigned hits;
        csmacd_pkg::step_result_t pending_ring [RING_DEPTH];
        int unsigned ring_wr;
        int unsigned ring_rd;
        int unsigned ring_used;
        int errors;

        function void reset_state();
            frame_len = csmacd_pkg::FRAME_LENGTH_RESET;
            slot_len = csmacd_pkg::SLOT_LENGTH_RESET;
            jam_len = csmacd_pkg::JAM_LENGTH_RESET;
            foreach (stamps[i]) stamps[i] = '0;
            head = 0;
            fill = 0;
            bit_time = '0;
            phase = 0;
            mode = ST_IDLE;
            remaining = 0;
            hits = 0;
            ring_wr = 0;
            ring_rd = 0;
            ring_used = 0;
            errors = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                csmacd_pkg::CFG_FRAME_LENGTH: frame_len = value;
                csmacd_pkg::CFG_SLOT_LENGTH:  slot_len = value[9:0];
                csmacd_pkg::CFG_JAM_LENGTH:   jam_len = value[7:0];
                default: ;
            endcase
        endfunction

        // Append one expectation at the tail of the ring
        function void note_expected(csmacd_pkg::step_result_t r);
            if (ring_used == RING_DEPTH) begin
                $error("expectation store overflow");
                errors++;
                return;
            end
            pending_ring[ring_wr] = r;
            ring_wr = (ring_wr + 1) % RING_DEPTH;
            ring_used++;
        endfunction

        // Advance the station by one bit time and queue the result it yields
        function void predict_step(csmacd_pkg::step_item_t it);
            csmacd_pkg::step_result_t r;
            int unsigned lost;
            int unsigned m;
            int unsigned k;
            logic delivered;
            logic [31:0] delay;
            lost = 0;
            delivered = 1'b0;
            delay = '0;

            // Stamp arrivals, drop those beyond the queue
            for (int i = 0; i < int'(it.new_frames); i++) begin
                if (fill < STATION_QUEUE_DEPTH) begin
                    stamps[(head + fill) % STATION_QUEUE_DEPTH] = bit_time;
                    fill++;
                end
                else
                    lost++;
            end

            // Turn a collision on our own transmission into jam
            if (mode == ST_SEND && (it.channel_busy || it.outside_collision)) begin
                mode = ST_JAM;
                remaining = jam_len;
                if (hits < csmacd_pkg::COLLISION_CAP)
                    hits++;
            end

            // Run down jam, backoff or transmission
            if (mode == ST_JAM) begin
                if (remaining > 0)
                    remaining--;
                if (remaining == 0) begin
                    m = (hits < csmacd_pkg::EXPONENT_CAP) ? hits : csmacd_pkg::EXPONENT_CAP;
                    k = it.backoff_draw & ((1 << m) - 1);
                    mode = ST_BACKOFF;
                    remaining = (k * slot_len) & 32'hFFFFF;
                end
            end
            else if (mode == ST_BACKOFF) begin
                if (remaining > 0)
                    remaining--;
                if (remaining == 0)
                    mode = ST_IDLE;
            end
            else if (mode == ST_SEND) begin
                if (remaining > 0)
                    remaining--;
                if (remaining == 0) begin
                    mode = ST_IDLE;
                    if (fill > 0) begin
                        delay = bit_time - stamps[head];
                        delivered = 1'b1;
                        head = (head + 1) % STATION_QUEUE_DEPTH;
                        fill--;
                    end
                    hits = 0;
                end
            end

            // Start a frame on a slot boundary when allowed
            if (mode == ST_IDLE && !it.channel_busy && phase == 0 && fill > 0
                && it.persist_granted) begin
                mode = ST_SEND;
                remaining = frame_len;
            end

            // Advance bit clock and slot phase
            bit_time++;
            phase++;
            if (phase >= slot_len)
                phase = 0;

            r.sending = (mode == ST_SEND);
            r.jamming = (mode == ST_JAM);
            r.backing_off = (mode == ST_BACKOFF);
            r.frame_delivered = delivered;
            r.delivery_delay = delay;
            r.queued_frames = fill[4:0];
            r.dropped_frames = lost[1:0];
            r.collision_count = hits[4:0];
            note_expected(r);
        endfunction

        function void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_step_result(logic [47:0] data);
            csmacd_pkg::step_result_t e;
            if (ring_used == 0) begin
                $error("result transaction with no expectation waiting: %h", data);
                errors++;
                return;
            end
            e = pending_ring[ring_rd];
            ring_rd = (ring_rd + 1) % RING_DEPTH;
            ring_used--;
            report_field("sending", e.sending, data[0]);
            report_field("jamming", e.jamming, data[1]);
            report_field("backing_off", e.backing_off, data[2]);
            report_field("frame_delivered", e.frame_delivered, data[3]);
            report_field("delivery_delay", e.delivery_delay, data[35:4]);
            report_field("queued_frames", e.queued_frames, data[40:36]);
            report_field("dropped_frames", e.dropped_frames, data[42:41]);
            report_field("collision_count", e.collision_count, data[47:43]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int cycle_count = 0;
    station_ledger ledger = new();

    csma_cd_station_mac_unit #(
        .QUEUE_DEPTH(STATION_QUEUE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result stream at random
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_step_result(m_axis_tdata);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL csma_cd_station_mac_unit");
            $finish;
        end
    end

    function automatic csmacd_pkg::step_item_t make_item(logic [1:0] frames, logic busy,
                                                         logic outside, logic granted,
                                                         logic [9:0] draw);
        csmacd_pkg::step_item_t it;
        it.new_frames = frames;
        it.channel_busy = busy;
        it.outside_collision = outside;
        it.persist_granted = granted;
        it.backoff_draw = draw;
        return it;
    endfunction

    // Random bit time: light traffic, frequent collisions, mostly short backoffs
    function automatic csmacd_pkg::step_item_t random_item();
        int r;
        logic [1:0] frames;
        logic [9:0] draw;
        r = $urandom_range(99);
        frames = (r < 60) ? 2'd0 : (r < 85) ? 2'd1 : (r < 95) ? 2'd2 : 2'd3;
        draw = ($urandom_range(1)) ? 10'($urandom_range(1023)) : 10'($urandom_range(3));
        return make_item(frames, $urandom_range(99) < 15, $urandom_range(99) < 15,
                         $urandom_range(99) < 70, draw);
    endfunction

    // Write one register; call at a falling edge with the block idle
    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        ledger.set_register(idx, value);
        @(negedge clk);
    endtask

    // Send one bit time; entered and left at a falling edge
    task automatic send_step(input csmacd_pkg::step_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, it.backoff_draw, it.persist_granted, it.outside_collision,
                         it.channel_busy, it.new_frames};
        do
            @(posedge clk);
        while (!s_axis_tready);
        ledger.predict_step(it);
        @(negedge clk);
    endtask

    // Hold off until every expected result has arrived and the pipeline is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ledger.ring_used != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [15:0] frame_w, input logic [15:0] slot_w,
                             input logic [15:0] jam_w, input int count);
        write_register(csmacd_pkg::CFG_FRAME_LENGTH, frame_w);
        write_register(csmacd_pkg::CFG_SLOT_LENGTH, slot_w);
        write_register(csmacd_pkg::CFG_JAM_LENGTH, jam_w);
        repeat (count) send_step(random_item());
        drain();
    endtask

    initial
    begin
        ledger.reset_state();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: fill past the queue, busy channel, collision, jam, backoff, delivery
        src_idle_pct = 17;
        sink_idle_pct = 55;
        write_register(csmacd_pkg::CFG_FRAME_LENGTH, 16'd3);
        write_register(csmacd_pkg::CFG_SLOT_LENGTH, 16'd1);
        write_register(csmacd_pkg::CFG_JAM_LENGTH, 16'd2);
        repeat (6) send_step(make_item(2'd3, 1'b0, 1'b0, 1'b0, 10'd0));
        send_step(make_item(2'd0, 1'b1, 1'b0, 1'b1, 10'd0));
        send_step(make_item(2'd0, 1'b0, 1'b0, 1'b1, 10'd0));
        send_step(make_item(2'd0, 1'b0, 1'b1, 1'b0, 10'd1023));
        send_step(make_item(2'd0, 1'b0, 1'b0, 1'b0, 10'd1023));
        send_step(make_item(2'd0, 1'b0, 1'b0, 1'b1, 10'd0));
        repeat (3) send_step(make_item(2'd0, 1'b0, 1'b0, 1'b0, 10'd0));
        send_step(make_item(2'd1, 1'b0, 1'b0, 1'b1, 10'd0));
        send_step(make_item(2'd2, 1'b1, 1'b1, 1'b0, 10'd0));
        send_step(make_item(2'd0, 1'b0, 1'b0, 1'b0, 10'd1022));
        send_step(make_item(2'd0, 1'b0, 1'b0, 1'b1, 10'd0));
        send_step(make_item(2'd0, 1'b0, 1'b0, 1'b1, 10'd0));
        send_step(make_item(2'd0, 1'b1, 1'b0, 1'b1, 10'd1023));
        drain();

        // Short lengths, upper register bits set to check masking
        run_phase(16'd5, {6'h3F, 10'd1}, {8'hFF, 8'd1}, 150);
        // Zero lengths
        run_phase(16'd0, 16'd0, 16'd0, 100);

        src_idle_pct = 55;
        sink_idle_pct = 17;
        run_phase(16'd12, 16'd4, 16'd3, 150);
        // Largest lengths
        run_phase(16'd65535, 16'd1023, 16'd255, 60);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_phase(16'd1, 16'd2, 16'd8, 150);
        write_register(CFG_UNUSED_INDEX, 16'd5);
        run_phase(csmacd_pkg::FRAME_LENGTH_RESET, 16'(csmacd_pkg::SLOT_LENGTH_RESET),
                  16'(csmacd_pkg::JAM_LENGTH_RESET), 120);

        if (ledger.errors == 0 && ledger.ring_used == 0)
            $display("PASS csma_cd_station_mac_unit");
        else
            $display("FAIL csma_cd_station_mac_unit");
        $finish;
    end

endmodule
